// ===== src/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants of the tile reveal pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package trp_pkg;

    // frame sequencing
    localparam int unsigned FillFrames   = 128;
    localparam int unsigned HoldFrames   = 14;
    localparam int unsigned CycleFrames  = FillFrames + HoldFrames;
    localparam int unsigned PatternCount = 6;
    // frame mod (CycleFrames * PatternCount) carries both phase and pattern
    localparam int unsigned SuperFrames  = CycleFrames * PatternCount;
    localparam logic [6:0]  MaxThreshold = 7'd127;
    localparam int unsigned RingSpan     = 40;

    localparam int unsigned RankW    = 8;
    localparam int unsigned PatternW = 3;

    // traversal orders
    localparam logic [PatternW-1:0] PAT_FORWARD = 3'd0;
    localparam logic [PatternW-1:0] PAT_REVERSE = 3'd1;
    localparam logic [PatternW-1:0] PAT_CENTRE  = 3'd2;
    localparam logic [PatternW-1:0] PAT_INV_CTR = 3'd3;
    localparam logic [PatternW-1:0] PAT_SNAKE   = 3'd4;
    localparam logic [PatternW-1:0] PAT_RING    = 3'd5;

    // per-tile data computed ahead of the frame math
    typedef struct packed {
        logic [RankW-1:0] rank_forward;
        logic [RankW-1:0] rank_reverse;
        logic [RankW-1:0] rank_centre;
        logic [RankW-1:0] rank_inv_ctr;
        logic [RankW-1:0] rank_snake;
        logic [RankW-1:0] rank_ring;
        logic             glyph_even;
        logic             glyph_odd;
        logic             tile_par;
    } trp_tile_info_t;

endpackage

`default_nettype wire

// ===== src/trp_tile_rank.sv =====
// ----------------------------------------------------------------------------
// trp_tile_rank
// Ranks of one tile under all six orders, and both glyph figures for a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_tile_rank (
    input  wire logic [3:0]          tile_x,
    input  wire logic [2:0]          tile_y,
    input  wire logic [2:0]          local_x,
    input  wire logic [2:0]          local_y,
    output trp_pkg::trp_tile_info_t  info
);
    import trp_pkg::*;

    logic [6:0] forward;
    logic [6:0] snake;
    logic [3:0] dx2;
    logic [2:0] dy2;
    logic [5:0] dx4;
    logic [5:0] dy8;
    logic [5:0] centre;
    logic [1:0] ring_x;
    logic [1:0] ring_y;
    logic [1:0] ring_idx;
    logic [5:0] snake_mod;
    logic       border;
    logic       even_fig;
    logic       odd_fig;

    always_comb begin
        forward = {tile_y, tile_x};
        snake   = tile_y[0] ? {tile_y, ~tile_x} : {tile_y, tile_x};

        // |2tx-15| and |2ty-7| are odd, so they come from a bit flip
        dx2 = tile_x[3] ? {tile_x[2:0], 1'b1} : {~tile_x[2:0], 1'b1};
        dy2 = tile_y[2] ? {tile_y[1:0], 1'b1} : {~tile_y[1:0], 1'b1};
        dx4 = {dx2, 2'b00};
        dy8 = {dy2, 3'b000};
        centre = ((dx4 > dy8) ? dx4 : dy8) + 6'(tile_y[2:1]);

        ring_x   = tile_x[3] ? ~tile_x[1:0] : tile_x[1:0];
        ring_x   = (tile_x[3] ? ~tile_x[2] : tile_x[2]) ? 2'd3 : ring_x;
        ring_y   = tile_y[2] ? ~tile_y[1:0] : tile_y[1:0];
        ring_idx = (ring_x < ring_y) ? ring_x : ring_y;

        if (snake >= 7'(3 * RingSpan)) begin
            snake_mod = 6'(snake - 7'(3 * RingSpan));
        end else if (snake >= 7'(2 * RingSpan)) begin
            snake_mod = 6'(snake - 7'(2 * RingSpan));
        end else if (snake >= 7'(RingSpan)) begin
            snake_mod = 6'(snake - 7'(RingSpan));
        end else begin
            snake_mod = 6'(snake);
        end

        info.rank_forward = RankW'(forward);
        info.rank_reverse = RankW'(MaxThreshold - forward);
        info.rank_centre  = RankW'(centre);
        // twice the centre rank stays below 127, so no clamp is needed
        info.rank_inv_ctr = RankW'(MaxThreshold - {centre, 1'b0});
        info.rank_snake   = RankW'(snake);
        info.rank_ring    = RankW'({ring_idx, 5'b00000}) + RankW'({ring_idx, 3'b000})
                          + RankW'(snake_mod);

        border = (local_x == 3'd0) || (local_x == 3'd7)
              || (local_y == 3'd0) || (local_y == 3'd7);

        even_fig = ((local_y <= 3'd3) && ((local_x == local_y) || (local_x == ~local_y)))
                || ((local_y == 3'd3) && ((local_x == 3'd3) || (local_x == 3'd4)))
                || ((local_x == 3'd3) && (local_y >= 3'd3));
        odd_fig  = ((local_y >= 3'd4) && ((local_x == ~local_y) || (local_x == local_y)))
                || ((local_y == 3'd4) && ((local_x == 3'd3) || (local_x == 3'd4)))
                || ((local_x == 3'd4) && (local_y <= 3'd4));

        info.glyph_even = border || even_fig;
        info.glyph_odd  = border || odd_fig;
        info.tile_par   = tile_x[0] ^ tile_y[0];
    end

endmodule

`default_nettype wire

// ===== src/tile_reveal_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// tile_reveal_pixel_generator_core
// Decides for each streamed pixel and frame number whether a cube glyph pixel
// is lit, with a five-stage pipeline.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_       | in        | pixel_x, pixel_y, frame_number
//   m_       | out       | pixel_on, tile_shown, order_pattern
//
// One transfer in and one out per clock while m_tready holds the output open.
// Stage 1 ranks the tile and folds the frame into a 19-bit residue,
// stages 2 and 3 reduce it to frame mod 852, stage 4 derives pattern and
// threshold, stage 5 selects the rank and registers the result.
// Each stage holds while the one after it is full and stalled; bubbles close.
// Reset (aresetn low, synchronous) empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_reveal_pixel_generator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [6:0] pixel_x, [12:7] pixel_y, [44:13] frame_number, [47:45] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] pixel_on, [1] tile_shown, [4:2] order_pattern, [7:5] zero
    output logic [7:0]       m_tdata
);
    import trp_pkg::*;

    // 2^(8i) mod 852 for the four frame bytes
    localparam logic [9:0] W1 = 10'(256);
    localparam logic [9:0] W2 = 10'(65536 % SuperFrames);
    localparam logic [9:0] W3 = 10'((65536 * 256) % SuperFrames);
    // 1024 mod 852
    localparam logic [7:0] FoldW = 8'(1024 - SuperFrames);

    logic [6:0]  in_px;
    logic [5:0]  in_py;
    logic [31:0] in_frame;

    trp_tile_info_t tile_info;

    // valid bits and stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    trp_tile_info_t s1_info_reg, s2_info_reg, s3_info_reg, s4_info_reg;
    logic [18:0] s1_res_reg;
    logic [14:0] s2_res_reg;
    logic [9:0]  s3_res_reg;
    logic [PatternW-1:0] s4_pattern_reg;
    logic [6:0]  s4_thresh_reg;
    logic [7:0]  out_reg;

    logic [18:0] res1_next;
    logic [16:0] fold_a;
    logic [14:0] res2_next;
    logic [12:0] fold_c;
    logic [11:0] fold_d;
    logic [10:0] fold_e;
    logic [10:0] fold_f;
    logic [9:0]  res3_next;
    logic [2:0]  cyc_idx;
    logic [9:0]  phase_full;
    logic [7:0]  phase;
    logic [PatternW-1:0] pattern_next;
    logic [6:0]  thresh_next;
    logic [RankW-1:0] sel_rank;
    logic        shown;
    logic        odd;
    logic        lit;

    assign in_px    = s_tdata[6:0];
    assign in_py    = s_tdata[12:7];
    assign in_frame = s_tdata[44:13];

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    trp_tile_rank u_tile_rank (
        .tile_x  (in_px[6:3]),
        .tile_y  (in_py[5:3]),
        .local_x (in_px[2:0]),
        .local_y (in_py[2:0]),
        .info    (tile_info)
    );

    always_comb begin
        res1_next = 19'(in_frame[7:0])
                  + 19'(in_frame[15:8])  * 19'(W1)
                  + 19'(in_frame[23:16]) * 19'(W2)
                  + 19'(in_frame[31:24]) * 19'(W3);

        // each fold keeps the value congruent mod 852
        fold_a    = 17'(s1_res_reg[9:0]) + 17'(s1_res_reg[18:10]) * 17'(FoldW);
        res2_next = 15'(fold_a[9:0]) + 15'(fold_a[16:10]) * 15'(FoldW);

        fold_c = 13'(s2_res_reg[9:0]) + 13'(s2_res_reg[14:10]) * 13'(FoldW);
        fold_d = 12'(fold_c[9:0]) + 12'(fold_c[12:10]) * 12'(FoldW);
        fold_e = 11'(fold_d[9:0]) + 11'(fold_d[11:10]) * 11'(FoldW);
        fold_f = 11'(fold_e[9:0]) + (fold_e[10] ? 11'(FoldW) : 11'd0);
        res3_next = (fold_f >= 11'(SuperFrames)) ? 10'(fold_f - 11'(SuperFrames))
                                                 : fold_f[9:0];

        if (s3_res_reg >= 10'(5 * CycleFrames)) begin
            cyc_idx = 3'd5;
        end else if (s3_res_reg >= 10'(4 * CycleFrames)) begin
            cyc_idx = 3'd4;
        end else if (s3_res_reg >= 10'(3 * CycleFrames)) begin
            cyc_idx = 3'd3;
        end else if (s3_res_reg >= 10'(2 * CycleFrames)) begin
            cyc_idx = 3'd2;
        end else if (s3_res_reg >= 10'(CycleFrames)) begin
            cyc_idx = 3'd1;
        end else begin
            cyc_idx = 3'd0;
        end
        phase_full = s3_res_reg - 10'(cyc_idx) * 10'(CycleFrames);
        phase      = phase_full[7:0];
        thresh_next = (phase >= 8'(FillFrames)) ? MaxThreshold : phase[6:0];

        // pattern = (5*cycle + 1) mod 6 = (1 - cycle) mod 6
        case (cyc_idx)
            3'd0:    pattern_next = PAT_REVERSE;
            3'd1:    pattern_next = PAT_FORWARD;
            3'd2:    pattern_next = PAT_RING;
            3'd3:    pattern_next = PAT_SNAKE;
            3'd4:    pattern_next = PAT_INV_CTR;
            default: pattern_next = PAT_CENTRE;
        endcase

        case (s4_pattern_reg)
            PAT_FORWARD: sel_rank = s4_info_reg.rank_forward;
            PAT_REVERSE: sel_rank = s4_info_reg.rank_reverse;
            PAT_CENTRE:  sel_rank = s4_info_reg.rank_centre;
            PAT_INV_CTR: sel_rank = s4_info_reg.rank_inv_ctr;
            PAT_SNAKE:   sel_rank = s4_info_reg.rank_snake;
            default:     sel_rank = s4_info_reg.rank_ring;
        endcase
        shown = sel_rank <= RankW'(s4_thresh_reg);
        odd   = s4_info_reg.tile_par ^ s4_pattern_reg[0];
        lit   = shown && (odd ? s4_info_reg.glyph_odd : s4_info_reg.glyph_even);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_info_reg <= tile_info;
            s1_res_reg  <= res1_next;
        end
        if (en2) begin
            s2_info_reg <= s1_info_reg;
            s2_res_reg  <= res2_next;
        end
        if (en3) begin
            s3_info_reg <= s2_info_reg;
            s3_res_reg  <= res3_next;
        end
        if (en4) begin
            s4_info_reg    <= s3_info_reg;
            s4_pattern_reg <= pattern_next;
            s4_thresh_reg  <= thresh_next;
        end
        if (en5) begin
            out_reg <= {3'b000, s4_pattern_reg, shown, lit};
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = out_reg;

    a_pattern_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:2] <= PAT_RING))
        else $error("order pattern out of range");

    a_lit_needs_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("pixel lit on a hidden tile");

    a_residue_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (s3_res_reg < 10'(SuperFrames)))
        else $error("frame residue not fully reduced");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !en5) |=> (v4_reg && $stable(s4_pattern_reg)))
        else $error("stalled stage lost its item");

endmodule

`default_nettype wire
